/* rtl/core/assert_macros.svh */
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MRDT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MRDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MRDT_ASSERT(lbl, clk, rst, prop, msg)

`define MRDT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/core/mrdt_pkg.sv */
// Types, constants and helpers for the multichannel reload down timer.
`default_nettype none

package mrdt_pkg;

  localparam int FUNC_W     = 2;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int CTRL_W     = 8;
  localparam int BIT_STRIDE = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  localparam logic [ADDR_W-1:0] ADDR_ENABLE     = 5'd0;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_EN     = 5'd1;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_STATUS = 5'd2;

  localparam int CHAN_BASE   = 4;
  localparam int CHAN_STRIDE = 4;
  localparam int OFF_CTRL    = 0;
  localparam int OFF_RELOAD  = 1;
  localparam int OFF_COUNT   = 2;

  function automatic logic [ADDR_W-1:0] chan_addr(input int unsigned ch,
                                                  input int unsigned off);
    return ADDR_W'(CHAN_BASE + ch * CHAN_STRIDE + off);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mrdt_req_if.sv */
// Request channel: tick, register write or register read.
`default_nettype none

interface mrdt_req_if;
  logic                         valid;
  logic                         ready;
  logic [mrdt_pkg::FUNC_W-1:0]  func;
  logic [mrdt_pkg::ADDR_W-1:0]  addr;
  logic [mrdt_pkg::DATA_W-1:0]  wdata;

  modport source (output valid, output func, output addr, output wdata, input ready);
  modport sink   (input valid, input func, input addr, input wdata, output ready);
endinterface

`default_nettype wire

/* rtl/core/mrdt_rsp_if.sv */
// Response channel: read data and interrupt line.
`default_nettype none

interface mrdt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [mrdt_pkg::DATA_W-1:0]  rdata;
  logic                         irq_line;

  modport source (output valid, output rdata, output irq_line, input ready);
  modport sink   (input valid, input rdata, input irq_line, output ready);
endinterface

`default_nettype wire

/* rtl/core/multichannel_reload_down_timer_unit.sv */
// Multichannel reload down timer with register access, one item per cycle while responses are taken.
//
//   channel | dir | payload                  | accepted when
//   --------+-----+--------------------------+---------------------------
//   req     | in  | func, addr, wdata        | req.valid && req.ready
//   rsp     | out | rdata, irq_line          | rsp.valid && rsp.ready
//
// State updates at the accepting edge and the
// result sits in the response register on the next cycle.
// One item per cycle sustained while rsp.ready stays high; the single response register sets the pace.
// req.ready is high while the response register is empty or being taken.
// Synchronous reset clears all registers; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module multichannel_reload_down_timer_unit #(
  parameter int NUM_CHANNELS = 4,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire        clk,
  input  wire        rst,
  mrdt_req_if.sink   req,
  mrdt_rsp_if.source rsp
);

  localparam int DW = mrdt_pkg::DATA_W;
  localparam int CW = mrdt_pkg::CTRL_W;
  localparam int BS = mrdt_pkg::BIT_STRIDE;

  logic [NUM_CHANNELS-1:0] enable, enable_next;
  logic [NUM_CHANNELS-1:0] irq_en, irq_en_next;
  logic [NUM_CHANNELS-1:0] status, status_next;
  logic [CW-1:0]           ctrl [NUM_CHANNELS];
  logic [CW-1:0]           ctrl_next [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  reload [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  reload_next [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  count [NUM_CHANNELS];
  logic [COUNT_WIDTH-1:0]  count_next [NUM_CHANNELS];

  logic          out_valid;
  logic [DW-1:0] out_rdata, rdata_next;
  logic          out_irq, irq_next;
  logic          acc;

  assign req.ready    = !out_valid || rsp.ready;
  assign acc          = req.valid && req.ready;
  assign rsp.valid    = out_valid;
  assign rsp.rdata    = out_rdata;
  assign rsp.irq_line = out_irq;

  always_comb begin
    enable_next = enable;
    irq_en_next = irq_en;
    status_next = status;
    rdata_next  = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      ctrl_next[ch]   = ctrl[ch];
      reload_next[ch] = reload[ch];
      count_next[ch]  = count[ch];
    end
    case (req.func)
      mrdt_pkg::FUNC_TICK: begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          if (enable[ch]) begin
            if (count[ch] == '0) begin
              count_next[ch]  = reload[ch];
              status_next[ch] = 1'b1;
            end else begin
              count_next[ch] = count[ch] - 1'b1;
            end
          end
        end
      end
      mrdt_pkg::FUNC_WRITE: begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          if (req.addr == mrdt_pkg::ADDR_ENABLE) begin
            enable_next[ch] = req.wdata[ch*BS];
            if (req.wdata[ch*BS] && !enable[ch]) begin
              count_next[ch] = reload[ch];
            end
          end
          if (req.addr == mrdt_pkg::ADDR_IRQ_EN) begin
            irq_en_next[ch] = req.wdata[ch*BS];
          end
          if (req.addr == mrdt_pkg::ADDR_IRQ_STATUS) begin
            status_next[ch] = status[ch] & ~req.wdata[ch*BS];
          end
          if (req.addr == mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_CTRL)) begin
            ctrl_next[ch] = req.wdata[CW-1:0];
          end
          if (req.addr == mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_RELOAD)) begin
            reload_next[ch] = req.wdata[COUNT_WIDTH-1:0];
          end
        end
      end
      mrdt_pkg::FUNC_READ: begin
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          if (req.addr == mrdt_pkg::ADDR_ENABLE) begin
            rdata_next[ch*BS] = enable[ch];
          end
          if (req.addr == mrdt_pkg::ADDR_IRQ_EN) begin
            rdata_next[ch*BS] = irq_en[ch];
          end
          if (req.addr == mrdt_pkg::ADDR_IRQ_STATUS) begin
            rdata_next[ch*BS] = status[ch];
          end
          if (req.addr == mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_CTRL)) begin
            rdata_next = DW'(ctrl[ch]);
          end
          if (req.addr == mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_RELOAD)) begin
            rdata_next = DW'(reload[ch]);
          end
          if (req.addr == mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_COUNT)) begin
            rdata_next = DW'(count[ch]);
          end
        end
      end
      default: begin
      end
    endcase
    irq_next = |(status_next & irq_en_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= '0;
      irq_en    <= '0;
      status    <= '0;
      out_valid <= 1'b0;
      out_rdata <= '0;
      out_irq   <= 1'b0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        ctrl[ch]   <= '0;
        reload[ch] <= '0;
        count[ch]  <= '0;
      end
    end else begin
      if (acc) begin
        enable    <= enable_next;
        irq_en    <= irq_en_next;
        status    <= status_next;
        out_valid <= 1'b1;
        out_rdata <= rdata_next;
        out_irq   <= irq_next;
        for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
          ctrl[ch]   <= ctrl_next[ch];
          reload[ch] <= reload_next[ch];
          count[ch]  <= count_next[ch];
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `MRDT_ASSERT(a_ready_when_empty, clk, rst, (!out_valid |-> req.ready), "ready low with empty output")
  `MRDT_ASSERT(a_irq_matches_state, clk, rst, (acc |=> (out_irq == (|(status & irq_en)))), "irq line does not match status and enables")
  `MRDT_ASSERT(a_rdata_zero_non_read, clk, rst, ((acc && req.func != mrdt_pkg::FUNC_READ) |=> (out_rdata == '0)), "nonzero rdata for non-read item")
  `MRDT_ASSERT(a_status_rise_on_tick, clk, rst, (!(acc && req.func == mrdt_pkg::FUNC_TICK) |=> ((status & ~$past(status)) == '0)), "status set without tick")
  `MRDT_ASSERT(a_disabled_frozen, clk, rst, ((!enable[0] && !(acc && req.func == mrdt_pkg::FUNC_WRITE && req.addr == mrdt_pkg::ADDR_ENABLE)) |=> $stable(count[0])), "disabled counter moved")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the four-channel reload down timer unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_CH        = 4;
  localparam int CNT_W       = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  localparam logic [15:0]                 CH_BITS      = 16'h1111;
  localparam logic [mrdt_pkg::FUNC_W-1:0] FUNC_NONE    = 2'd3;
  localparam logic [mrdt_pkg::ADDR_W-1:0] ADDR_HOLE    = 5'd3;
  localparam logic [mrdt_pkg::ADDR_W-1:0] ADDR_TOP     = 5'd31;
  localparam int                          OFF_UNMAPPED = 3;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_EVERY3, STALL_HEAVY} stall_mode_t;

  typedef struct packed {
    logic [mrdt_pkg::DATA_W-1:0] rdata;
    logic                        irq_line;
  } timer_result_t;

  logic clk;
  logic rst;

  mrdt_req_if req_if ();
  mrdt_rsp_if rsp_if ();

  multichannel_reload_down_timer_unit #(
    .NUM_CHANNELS(N_CH),
    .COUNT_WIDTH (CNT_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  logic [15:0]                 model_en;
  logic [15:0]                 model_irq_en;
  logic [15:0]                 model_irq_flags;
  logic [mrdt_pkg::CTRL_W-1:0] ch_ctrl   [N_CH];
  logic [CNT_W-1:0]            ch_reload [N_CH];
  logic [CNT_W-1:0]            ch_count  [N_CH];

  timer_result_t result_q[$];
  int unsigned   n_fail;
  int unsigned   n_checked;
  int unsigned   cycle_cnt;
  int unsigned   burst_left;
  stall_mode_t   stall_mode;
  int unsigned   stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic timer_result_t timer_step(input logic [mrdt_pkg::FUNC_W-1:0] fn,
                                               input logic [mrdt_pkg::ADDR_W-1:0] ad,
                                               input logic [mrdt_pkg::DATA_W-1:0] wd);
    timer_result_t res;
    logic [15:0]   turned_on;
    int unsigned   ch;
    int unsigned   off;
    res = '0;
    case (fn)
      mrdt_pkg::FUNC_TICK: begin
        for (ch = 0; ch < N_CH; ch++) begin
          if (model_en[ch*mrdt_pkg::BIT_STRIDE]) begin
            if (ch_count[ch] == '0) begin
              ch_count[ch] = ch_reload[ch];
              model_irq_flags[ch*mrdt_pkg::BIT_STRIDE] = 1'b1;
            end else begin
              ch_count[ch] = ch_count[ch] - 1'b1;
            end
          end
        end
      end
      mrdt_pkg::FUNC_WRITE: begin
        if (ad == mrdt_pkg::ADDR_ENABLE) begin
          turned_on = wd[15:0] & CH_BITS & ~model_en;
          for (ch = 0; ch < N_CH; ch++) begin
            if (turned_on[ch*mrdt_pkg::BIT_STRIDE]) ch_count[ch] = ch_reload[ch];
          end
          model_en = wd[15:0] & CH_BITS;
        end else if (ad == mrdt_pkg::ADDR_IRQ_EN) begin
          model_irq_en = wd[15:0] & CH_BITS;
        end else if (ad == mrdt_pkg::ADDR_IRQ_STATUS) begin
          model_irq_flags = model_irq_flags & ~wd[15:0] & CH_BITS;
        end else if (ad >= mrdt_pkg::CHAN_BASE) begin
          ch  = (ad - mrdt_pkg::CHAN_BASE) / mrdt_pkg::CHAN_STRIDE;
          off = (ad - mrdt_pkg::CHAN_BASE) % mrdt_pkg::CHAN_STRIDE;
          if (ch < N_CH) begin
            if (off == mrdt_pkg::OFF_CTRL) ch_ctrl[ch] = wd[mrdt_pkg::CTRL_W-1:0];
            else if (off == mrdt_pkg::OFF_RELOAD) ch_reload[ch] = wd[CNT_W-1:0];
          end
        end
      end
      mrdt_pkg::FUNC_READ: begin
        if (ad == mrdt_pkg::ADDR_ENABLE) begin
          res.rdata = mrdt_pkg::DATA_W'(model_en);
        end else if (ad == mrdt_pkg::ADDR_IRQ_EN) begin
          res.rdata = mrdt_pkg::DATA_W'(model_irq_en);
        end else if (ad == mrdt_pkg::ADDR_IRQ_STATUS) begin
          res.rdata = mrdt_pkg::DATA_W'(model_irq_flags);
        end else if (ad >= mrdt_pkg::CHAN_BASE) begin
          ch  = (ad - mrdt_pkg::CHAN_BASE) / mrdt_pkg::CHAN_STRIDE;
          off = (ad - mrdt_pkg::CHAN_BASE) % mrdt_pkg::CHAN_STRIDE;
          if (ch < N_CH) begin
            if (off == mrdt_pkg::OFF_CTRL) begin
              res.rdata = mrdt_pkg::DATA_W'(ch_ctrl[ch]);
            end else if (off == mrdt_pkg::OFF_RELOAD) begin
              res.rdata = mrdt_pkg::DATA_W'(ch_reload[ch]);
            end else if (off == mrdt_pkg::OFF_COUNT) begin
              res.rdata = mrdt_pkg::DATA_W'(ch_count[ch]);
            end
          end
        end
      end
      default: ;
    endcase
    res.irq_line = |(model_irq_flags & model_irq_en);
    return res;
  endfunction

  task automatic send_item(input logic [mrdt_pkg::FUNC_W-1:0] fn,
                           input logic [mrdt_pkg::ADDR_W-1:0] ad,
                           input logic [mrdt_pkg::DATA_W-1:0] wd);
    int unsigned gap;
    logic        taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.func  <= fn;
    req_if.addr  <= ad;
    req_if.wdata <= wd;
    do begin
      @(negedge clk);
      taken = req_if.ready;
      @(posedge clk);
    end while (!taken);
    result_q.push_back(timer_step(fn, ad, wd));
  endtask

  task automatic wait_results_drained();
    req_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_register_map();
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::chan_addr(0, mrdt_pkg::OFF_RELOAD), 32'd2);
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::chan_addr(3, mrdt_pkg::OFF_RELOAD),
              32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::chan_addr(1, mrdt_pkg::OFF_CTRL),
              32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::chan_addr(0, mrdt_pkg::OFF_COUNT),
              32'hdead_beef);
    send_item(mrdt_pkg::FUNC_WRITE, ADDR_HOLE, 32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_WRITE, ADDR_TOP, 32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::chan_addr(1, mrdt_pkg::OFF_CTRL), '0);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::chan_addr(3, mrdt_pkg::OFF_RELOAD), '0);
    send_item(mrdt_pkg::FUNC_READ, ADDR_HOLE, '0);
    send_item(mrdt_pkg::FUNC_READ, ADDR_TOP, '0);
    send_item(FUNC_NONE, mrdt_pkg::chan_addr(3, mrdt_pkg::OFF_RELOAD), 32'hffff_ffff);
  endtask

  task automatic test_expiry_and_irq();
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::ADDR_IRQ_EN, 32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::ADDR_ENABLE, 32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::ADDR_ENABLE, '0);
    repeat (3) send_item(mrdt_pkg::FUNC_TICK, '0, '0);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::ADDR_IRQ_STATUS, '0);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::chan_addr(0, mrdt_pkg::OFF_COUNT), '0);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::chan_addr(3, mrdt_pkg::OFF_COUNT), '0);
  endtask

  task automatic test_enable_rewrite_and_clear();
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::ADDR_ENABLE, 32'h0000_0001);
    send_item(mrdt_pkg::FUNC_TICK, '0, '0);
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::ADDR_IRQ_STATUS, 32'hffff_ffff);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::ADDR_IRQ_STATUS, '0);
    send_item(mrdt_pkg::FUNC_WRITE, mrdt_pkg::ADDR_ENABLE, '0);
    send_item(mrdt_pkg::FUNC_READ, mrdt_pkg::chan_addr(3, mrdt_pkg::OFF_COUNT), '0);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned                 pick;
    int unsigned                 kind;
    int unsigned                 ch;
    int unsigned                 idx;
    logic [3:0]                  en_bits;
    logic [mrdt_pkg::FUNC_W-1:0] fn;
    logic [mrdt_pkg::ADDR_W-1:0] ad;
    logic [mrdt_pkg::DATA_W-1:0] wd;
    for (idx = 0; idx < n_items; idx++) begin
      if (idx % 400 == 399) wait_results_drained();
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 5);
      ch   = $urandom_range(0, N_CH - 1);
      wd   = $urandom;
      case (kind)
        0:       ad = mrdt_pkg::ADDR_ENABLE;
        1:       ad = mrdt_pkg::ADDR_IRQ_EN;
        2:       ad = mrdt_pkg::ADDR_IRQ_STATUS;
        3:       ad = mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_CTRL);
        4:       ad = mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_RELOAD);
        default: ad = mrdt_pkg::chan_addr(ch, mrdt_pkg::OFF_COUNT);
      endcase
      if (pick < 40) begin
        fn = mrdt_pkg::FUNC_TICK;
      end else if (pick < 62) begin
        fn = mrdt_pkg::FUNC_READ;
      end else if (pick < 90) begin
        fn = mrdt_pkg::FUNC_WRITE;
        if (kind <= 1 && $urandom_range(0, 1) == 0) begin
          en_bits = 4'($urandom_range(0, 15));
          wd = '0;
          for (ch = 0; ch < N_CH; ch++) wd[ch*mrdt_pkg::BIT_STRIDE] = en_bits[ch];
        end else if (kind == 4) begin
          pick = $urandom_range(0, 99);
          if (pick < 70) wd = mrdt_pkg::DATA_W'($urandom_range(0, 6));
          else if (pick < 85) wd = mrdt_pkg::DATA_W'($urandom_range(0, 40));
          else if (pick < 93) wd = 32'hffff_ffff - $urandom_range(0, 3);
        end
      end else begin
        fn = mrdt_pkg::FUNC_W'($urandom_range(0, 3));
        ad = mrdt_pkg::ADDR_W'($urandom_range(0, 31));
        if ($urandom_range(0, 1) == 0) begin
          ad = mrdt_pkg::chan_addr($urandom_range(0, N_CH - 1), OFF_UNMAPPED);
        end
      end
      send_item(fn, ad, wd);
    end
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(32, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   rsp_if.ready <= 1'b1;
      STALL_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
      STALL_EVERY3: rsp_if.ready <= (cycle_cnt % 3 == 0);
      default:      rsp_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(negedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      n_checked++;
      if (result_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("result %0d arrived with nothing expected: rdata=%h irq=%0b",
                   n_checked, rsp_if.rdata, rsp_if.irq_line);
      end else if (rsp_if.rdata !== result_q[0].rdata ||
                   rsp_if.irq_line !== result_q[0].irq_line) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("result %0d: expected rdata=%h irq=%0b, got rdata=%h irq=%0b",
                   n_checked, result_q[0].rdata, result_q[0].irq_line,
                   rsp_if.rdata, rsp_if.irq_line);
        void'(result_q.pop_front());
      end else begin
        void'(result_q.pop_front());
      end
    end
  end

  initial begin
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.func     = mrdt_pkg::FUNC_TICK;
    req_if.addr     = '0;
    req_if.wdata    = '0;
    rsp_if.ready    = 1'b0;
    model_en        = '0;
    model_irq_en    = '0;
    model_irq_flags = '0;
    for (int i = 0; i < N_CH; i++) begin
      ch_ctrl[i]   = '0;
      ch_reload[i] = '0;
      ch_count[i]  = '0;
    end
    n_fail     = 0;
    n_checked  = 0;
    cycle_cnt  = 0;
    burst_left = 0;
    stall_mode = STALL_NONE;
    stall_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_register_map();
    test_expiry_and_irq();
    test_enable_rewrite_and_clear();
    test_random_traffic(1520);
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
